### design/rdr_pkg.sv
// Package with the item types, register indexes and the square-root table.
`timescale 1ns / 1ps
`default_nettype none
package rdr_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_TABLE_LAST    = 2'd2,
    CFG_SUBPIXEL_MODE = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic               opcode;
    logic [10:0]        pixel_col;
    logic [10:0]        pixel_row;
    logic [10:0]        entry_index;
    logic signed [15:0] entry_gain;
  } in_item_t;

  typedef struct packed {
    logic [10:0] source_col;
    logic [10:0] source_row;
    logic [7:0]  frac_col;
    logic [7:0]  frac_row;
    logic [10:0] radius_index;
  } out_item_t;

  localparam int CFG_DATA_W = 12;
  localparam int ADDR_EXT_W = 12;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [10:0] LAST_RESET   = 11'd431;

  localparam logic [7:0] ROOT_LUT [256] = '{
    8'd0, 8'd16, 8'd22, 8'd27, 8'd32, 8'd35, 8'd39, 8'd42, 8'd45, 8'd48, 8'd50, 8'd53,
    8'd55, 8'd57, 8'd59, 8'd61, 8'd64, 8'd65, 8'd67, 8'd69, 8'd71, 8'd73, 8'd75, 8'd76,
    8'd78, 8'd80, 8'd81, 8'd83, 8'd84, 8'd86, 8'd87, 8'd89, 8'd90, 8'd91, 8'd93, 8'd94,
    8'd96, 8'd97, 8'd98, 8'd99, 8'd101, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108,
    8'd109, 8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
    8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd128, 8'd128, 8'd129,
    8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd137, 8'd138, 8'd139,
    8'd140, 8'd141, 8'd142, 8'd143, 8'd144, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148,
    8'd149, 8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155, 8'd156,
    8'd157, 8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162, 8'd163, 8'd163, 8'd164,
    8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170, 8'd170, 8'd171, 8'd172,
    8'd173, 8'd173, 8'd174, 8'd175, 8'd176, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179,
    8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186,
    8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191, 8'd192, 8'd192, 8'd193,
    8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197, 8'd198, 8'd199, 8'd199,
    8'd200, 8'd201, 8'd201, 8'd202, 8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206,
    8'd206, 8'd207, 8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211, 8'd212,
    8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd217, 8'd217, 8'd218,
    8'd218, 8'd219, 8'd219, 8'd220, 8'd221, 8'd221, 8'd222, 8'd222, 8'd223, 8'd224,
    8'd224, 8'd225, 8'd225, 8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229,
    8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234, 8'd235,
    8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239, 8'd240, 8'd240,
    8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245,
    8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250,
    8'd251, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255
  };

  // Table square root of a value below 2^24, scaled by the range it falls in.
  function automatic logic [11:0] approx_root(input logic [23:0] n);
    logic [11:0] t;
    begin
      if (n >= 24'h400000) begin
        t = {ROOT_LUT[n[23:16]], 4'd0};
      end else if (n >= 24'h100000) begin
        t = {1'b0, ROOT_LUT[n[21:14]], 3'd0};
      end else if (n >= 24'h040000) begin
        t = {2'd0, ROOT_LUT[n[19:12]], 2'd0};
      end else if (n >= 24'h010000) begin
        t = {3'd0, ROOT_LUT[n[17:10]], 1'b0};
      end else if (n >= 24'h004000) begin
        t = {4'd0, ROOT_LUT[n[15:8]]};
      end else if (n >= 24'h001000) begin
        t = 12'(ROOT_LUT[n[13:6]] >> 1);
      end else if (n >= 24'h000400) begin
        t = 12'(ROOT_LUT[n[11:4]] >> 2);
      end else if (n >= 24'h000100) begin
        t = 12'(ROOT_LUT[n[9:2]] >> 3);
      end else if (n >= 24'h000040) begin
        t = 12'(ROOT_LUT[n[7:0]] >> 4);
      end else if (n >= 24'h000010) begin
        t = 12'(ROOT_LUT[{n[5:0], 2'd0}] >> 5);
      end else if (n >= 24'h000004) begin
        t = 12'(ROOT_LUT[{n[3:0], 4'd0}] >> 6);
      end else begin
        t = 12'(ROOT_LUT[{n[1:0], 6'd0}] >> 7);
      end
      return t;
    end
  endfunction

endpackage
`default_nettype wire

### design/rdr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/rdr_axis.sv
// One axis of the remap: whole part, centre offset, clamp and fraction.
`timescale 1ns / 1ps
`default_nettype none
module rdr_axis (
  input  wire logic signed [28:0] scaled,
  input  wire logic [10:0]        centre,
  input  wire logic [11:0]        size,
  input  wire logic               sub,
  output logic      [10:0]        src,
  output logic      [7:0]         frac
);

  logic signed [20:0] whole;
  logic signed [21:0] pos;
  logic [11:0]        hi;
  logic [11:0]        clamped;

  always_comb begin
    whole = scaled[28:8];
    pos   = {11'd0, centre} + {whole[20], whole};
    hi    = sub ? (size - 12'd2) : (size - 12'd1);
    if (pos[21]) begin
      clamped = 12'd0;
    end else if (pos[20:0] > {9'd0, hi}) begin
      clamped = hi;
    end else begin
      clamped = pos[11:0];
    end
    src  = clamped[10:0];
    frac = sub ? scaled[7:0] : 8'd0;
  end

endmodule
`default_nettype wire

### design/radial_distance_remap_unit.sv
// Top level of the radial distance remap source-coordinate generator.
// A map request passes through the pipeline stages and the output register to the output.
// Throughput: one request per cycle while the output does not stall; table writes and reads share the RAM port stage.
// Table writes pass down the pipeline and update the gain RAM at the read stage.
// Reset clears the pipeline valid bits and restores the configuration registers.
// The gain table is not cleared by reset; entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module radial_distance_remap_unit #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int TABLE_DEPTH = 2048
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rdr_pkg::in_item_t                   in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rdr_pkg::out_item_t                       out_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [rdr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int ADDR_EXT_W_L = rdr_pkg::ADDR_EXT_W;

  logic [11:0] image_width_r;
  logic [11:0] image_height_r;
  logic [10:0] table_last_r;
  logic        subpixel_mode_r;

  logic [11:0] w_size;
  logic [11:0] h_size;
  logic [10:0] w_half;
  logic [10:0] h_half;

  logic ld1, ld2, ld3, ld4, ld5, ld6, ld_o;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  rdr_pkg::in_item_t  item1_r;
  logic signed [11:0] dx2_r, dy2_r, dx3_r, dy3_r, dx4_r, dy4_r, dx5_r, dy5_r;
  logic               op2_r, op3_r, op4_r;
  logic [10:0]        idx2_r, idx3_r, idx4_r;
  logic [15:0]        gain2_r, gain3_r, gain4_r;
  logic [21:0]        sqx3_r, sqy3_r;
  logic [23:0]        n4_r;
  logic [10:0]        r5_r, r6_r;
  logic signed [28:0] vx6_r, vy6_r;
  rdr_pkg::out_item_t out_r;

  logic signed [11:0] dx2_nxt, dy2_nxt;
  logic signed [23:0] sqx_full, sqy_full;
  logic signed [24:0] n_sum;
  logic [11:0]        root_raw;
  logic [11:0]        root_lim;
  logic [10:0]        r5_nxt;
  logic [ADDR_EXT_W_L-1:0] rd_addr_ext;
  logic [ADDR_EXT_W_L-1:0] wr_addr_ext;
  logic               wr_in_range;
  logic [15:0]        ram_rd_data;
  logic signed [15:0] q5;
  logic signed [27:0] px6, py6;
  logic signed [28:0] vx6_nxt, vy6_nxt;
  logic [10:0]        src_col, src_row;
  logic [7:0]         fr_col, fr_row;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= rdr_pkg::WIDTH_RESET;
      image_height_r  <= rdr_pkg::HEIGHT_RESET;
      table_last_r    <= rdr_pkg::LAST_RESET;
      subpixel_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rdr_pkg::cfg_index_t'(cfg_index))
        rdr_pkg::CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data[11:0];
        rdr_pkg::CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[11:0];
        rdr_pkg::CFG_TABLE_LAST:    table_last_r    <= cfg_data[10:0];
        rdr_pkg::CFG_SUBPIXEL_MODE: subpixel_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_r < 12'd2) begin
      w_size = 12'd2;
    end else if ({1'b0, image_width_r} > 13'(MAX_WIDTH)) begin
      w_size = 12'(MAX_WIDTH);
    end else begin
      w_size = image_width_r;
    end
    if (image_height_r < 12'd2) begin
      h_size = 12'd2;
    end else if ({1'b0, image_height_r} > 13'(MAX_HEIGHT)) begin
      h_size = 12'(MAX_HEIGHT);
    end else begin
      h_size = image_height_r;
    end
    w_half = w_size[11:1];
    h_half = h_size[11:1];
  end

  // Each stage loads when it is empty or its request moves on.
  assign ld_o     = !out_valid_r || !out_stall;
  assign ld6      = !v6_r || ld_o;
  assign ld5      = !v5_r || ld6;
  assign ld4      = !v4_r || ld5;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r && (op4_r == rdr_pkg::OP_MAP);
      if (ld6) v6_r <= v5_r;
      if (ld_o) out_valid_r <= v6_r;
    end
  end

  // Datapath.
  always_comb begin
    dx2_nxt  = $signed({1'b0, item1_r.pixel_col}) - $signed({1'b0, w_half});
    dy2_nxt  = $signed({1'b0, item1_r.pixel_row}) - $signed({1'b0, h_half});
    sqx_full = dx2_r * dx2_r;
    sqy_full = dy2_r * dy2_r;
    n_sum    = $signed({3'd0, sqx3_r}) - 25'(dx3_r) + $signed({3'd0, sqy3_r})
               + 25'sd256;
    root_raw = rdr_pkg::approx_root(n4_r);
    root_lim = (root_raw > {1'b0, table_last_r}) ? {1'b0, table_last_r} : root_raw;
    if (root_lim > 12'(TABLE_DEPTH - 1)) begin
      root_lim = 12'(TABLE_DEPTH - 1);
    end
    r5_nxt      = root_lim[10:0];
    rd_addr_ext = {1'b0, r5_nxt};
    wr_addr_ext = {1'b0, idx4_r};
    wr_in_range = {2'd0, idx4_r} < 13'(TABLE_DEPTH);
    q5          = $signed(ram_rd_data);
    px6         = q5 * dx5_r;
    py6         = q5 * dy5_r;
    vx6_nxt     = 29'(px6) + 29'sd128;
    vy6_nxt     = 29'(py6) + 29'sd128;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      item1_r <= in_item;
    end
    if (ld2) begin
      dx2_r   <= dx2_nxt;
      dy2_r   <= dy2_nxt;
      op2_r   <= item1_r.opcode;
      idx2_r  <= item1_r.entry_index;
      gain2_r <= item1_r.entry_gain;
    end
    if (ld3) begin
      sqx3_r  <= sqx_full[21:0];
      sqy3_r  <= sqy_full[21:0];
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      op3_r   <= op2_r;
      idx3_r  <= idx2_r;
      gain3_r <= gain2_r;
    end
    if (ld4) begin
      n4_r    <= n_sum[23:0];
      dx4_r   <= dx3_r;
      dy4_r   <= dy3_r;
      op4_r   <= op3_r;
      idx4_r  <= idx3_r;
      gain4_r <= gain3_r;
    end
    if (ld5) begin
      r5_r  <= r5_nxt;
      dx5_r <= dx4_r;
      dy5_r <= dy4_r;
    end
    if (ld6) begin
      vx6_r <= vx6_nxt;
      vy6_r <= vy6_nxt;
      r6_r  <= r5_r;
    end
    if (ld_o) begin
      out_r.source_col   <= src_col;
      out_r.source_row   <= src_row;
      out_r.frac_col     <= fr_col;
      out_r.frac_row     <= fr_row;
      out_r.radius_index <= r6_r;
    end
  end

  rdr_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_gain_ram (
    .clk     (clk),
    .wr_en   (ld5 && v4_r && (op4_r == rdr_pkg::OP_WRITE) && wr_in_range),
    .wr_addr (wr_addr_ext[AW-1:0]),
    .wr_data (gain4_r),
    .rd_en   (ld5),
    .rd_addr (rd_addr_ext[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  rdr_axis u_axis_col (
    .scaled (vx6_r),
    .centre (w_half),
    .size   (w_size),
    .sub    (subpixel_mode_r),
    .src    (src_col),
    .frac   (fr_col)
  );

  rdr_axis u_axis_row (
    .scaled (vy6_r),
    .centre (h_half),
    .size   (h_size),
    .sub    (subpixel_mode_r),
    .src    (src_row),
    .frac   (fr_row)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire
